@@ hw/rtl/eulrot_pkg.sv @@
// Shared types, constants and helper functions for the Euler XYZ rotation matrix block.
// Used by the channel interfaces and every module under hw/rtl.
// No dependencies.
package eulrot_pkg;

   // sine table depth must be a power of two
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int OUT_FRAC_BITS    = 14;

   localparam int ANGLE_W = 16;
   localparam int OUT_W   = 16;

   localparam int TAB_LOG  = $clog2(SINE_TABLE_DEPTH);
   localparam int PHASE_W  = TAB_LOG + 2;
   localparam int ADDR_W   = TAB_LOG + 1;
   localparam int MAG_W    = OUT_FRAC_BITS + 1;
   localparam int VAL_W    = OUT_FRAC_BITS + 2;
   localparam int PROD_W   = 2 * MAG_W;

   // full turn in 1/64 degree = TURN_ODD << TURN_SHIFT
   localparam int FULL_TURN  = 23040;
   localparam int HALF_TURN  = FULL_TURN / 2;
   localparam int TURN_SHIFT = 9;
   localparam int TURN_ODD   = 45;
   localparam int TWO_TURNS  = 2 * FULL_TURN;
   localparam int RED_W      = $clog2((1 << (ANGLE_W - 1)) + TWO_TURNS);
   localparam int MOD_W      = $clog2(FULL_TURN);
   localparam int NUM_W      = $clog2(longint'(FULL_TURN) * 4 * SINE_TABLE_DEPTH);
   localparam int N2_W       = NUM_W - TURN_SHIFT;
   localparam int RECIP_SHIFT = N2_W + 6;
   localparam longint RECIP  = ((longint'(1) << RECIP_SHIFT) + TURN_ODD - 1) / TURN_ODD;
   localparam int RECIP_W    = RECIP_SHIFT - 5;
   localparam int PRODQ_W    = N2_W + RECIP_W;
   localparam int QE_W       = PRODQ_W - RECIP_SHIFT;
   localparam int CORR_W     = QE_W + 6;

   // pipeline: 3 phase stages, 3 table stages, 5 product/sum stages
   localparam int PHASE_STAGES   = 3;
   localparam int SINCOS_STAGES  = 3;
   localparam int COMBINE_STAGES = 5;
   localparam int NUM_STAGES     = PHASE_STAGES + SINCOS_STAGES + COMBINE_STAGES;

   localparam longint HALF_PI_Q30 = 64'd1686629713;

   typedef logic [MAG_W-1:0] tab_type [0:SINE_TABLE_DEPTH];

   typedef struct packed {
      logic signed [VAL_W-1:0] sx;
      logic signed [VAL_W-1:0] cx;
      logic signed [VAL_W-1:0] sy;
      logic signed [VAL_W-1:0] cy;
      logic signed [VAL_W-1:0] sz;
      logic signed [VAL_W-1:0] cz;
   } trig_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] r0c0;
      logic signed [OUT_W-1:0] r0c1;
      logic signed [OUT_W-1:0] r0c2;
      logic signed [OUT_W-1:0] r1c0;
      logic signed [OUT_W-1:0] r1c1;
      logic signed [OUT_W-1:0] r1c2;
      logic signed [OUT_W-1:0] r2c0;
      logic signed [OUT_W-1:0] r2c1;
      logic signed [OUT_W-1:0] r2c2;
   } matrix_type;

   localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (OUT_FRAC_BITS - 1);
   localparam logic signed [VAL_W:0] SAT_HI = (VAL_W + 1)'(1) << OUT_FRAC_BITS;
   localparam logic signed [VAL_W:0] SAT_LO = -SAT_HI;

   // quarter-wave sine, Taylor series in Q30, rounded half up
   function automatic tab_type build_sine_table();
      tab_type t;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint sum;
      longint unsigned rnd;
      int s;
      s   = 30 - OUT_FRAC_BITS;
      rnd = (longint'(1) << s) >> 1;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x    = (longint'(i) * HALF_PI_Q30 + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
         x2   = (x * x + (longint'(1) << 29)) >> 30;
         term = x;
         sum  = longint'(x);
         // twelve terms, divisors (2k)(2k+1)
         term = ((term * x2) >> 30) / 64'd6;
         sum  = sum - longint'(term);
         term = ((term * x2) >> 30) / 64'd20;
         sum  = sum + longint'(term);
         term = ((term * x2) >> 30) / 64'd42;
         sum  = sum - longint'(term);
         term = ((term * x2) >> 30) / 64'd72;
         sum  = sum + longint'(term);
         term = ((term * x2) >> 30) / 64'd110;
         sum  = sum - longint'(term);
         term = ((term * x2) >> 30) / 64'd156;
         sum  = sum + longint'(term);
         term = ((term * x2) >> 30) / 64'd210;
         sum  = sum - longint'(term);
         term = ((term * x2) >> 30) / 64'd272;
         sum  = sum + longint'(term);
         term = ((term * x2) >> 30) / 64'd342;
         sum  = sum - longint'(term);
         term = ((term * x2) >> 30) / 64'd420;
         sum  = sum + longint'(term);
         term = ((term * x2) >> 30) / 64'd506;
         sum  = sum - longint'(term);
         term = ((term * x2) >> 30) / 64'd600;
         sum  = sum + longint'(term);
         if (sum < 0) begin
            sum = 0;
         end
         if (sum > (longint'(1) << 30)) begin
            sum = longint'(1) << 30;
         end
         t[i] = MAG_W'((longint'(sum) + rnd) >> s);
      end
      t[0] = '0;
      t[SINE_TABLE_DEPTH] = MAG_W'(longint'(1) << OUT_FRAC_BITS);
      return t;
   endfunction

   function automatic logic [MAG_W-1:0] mag_of(logic signed [VAL_W-1:0] v);
      logic [VAL_W-1:0] a;
      a = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
      return a[MAG_W-1:0];
   endfunction

   function automatic logic signed [VAL_W-1:0] round_prod(logic [PROD_W-1:0] pm, logic neg);
      logic [PROD_W:0] s;
      logic signed [VAL_W-1:0] m;
      s = {1'b0, pm} + ROUND_HALF;
      m = signed'({1'b0, s[OUT_FRAC_BITS +: MAG_W]});
      return neg ? -m : m;
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_pack(logic signed [VAL_W:0] v);
      logic signed [VAL_W:0] c;
      if (v > SAT_HI) begin
         c = SAT_HI;
      end else if (v < SAT_LO) begin
         c = SAT_LO;
      end else begin
         c = v;
      end
      return OUT_W'(c);
   endfunction

endpackage

@@ hw/rtl/eulrot_req_if.sv @@
// Input channel: one word of three angles with valid/ready.
// Depends on eulrot_pkg.
interface eulrot_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [eulrot_pkg::ANGLE_W-1:0] angle_x;
   logic signed [eulrot_pkg::ANGLE_W-1:0] angle_y;
   logic signed [eulrot_pkg::ANGLE_W-1:0] angle_z;

   modport source (output valid, output angle_x, output angle_y, output angle_z, input ready);
   modport sink (input valid, input angle_x, input angle_y, input angle_z, output ready);
endinterface

@@ hw/rtl/eulrot_rsp_if.sv @@
// Result channel: one word of nine matrix entries with valid/ready.
// Depends on eulrot_pkg.
interface eulrot_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [eulrot_pkg::OUT_W-1:0] r0c0;
   logic signed [eulrot_pkg::OUT_W-1:0] r0c1;
   logic signed [eulrot_pkg::OUT_W-1:0] r0c2;
   logic signed [eulrot_pkg::OUT_W-1:0] r1c0;
   logic signed [eulrot_pkg::OUT_W-1:0] r1c1;
   logic signed [eulrot_pkg::OUT_W-1:0] r1c2;
   logic signed [eulrot_pkg::OUT_W-1:0] r2c0;
   logic signed [eulrot_pkg::OUT_W-1:0] r2c1;
   logic signed [eulrot_pkg::OUT_W-1:0] r2c2;

   modport source (output valid, output r0c0, output r0c1, output r0c2, output r1c0,
                   output r1c1, output r1c2, output r2c0, output r2c1, output r2c2,
                   input ready);
   modport sink (input valid, input r0c0, input r0c1, input r0c2, input r1c0,
                 input r1c1, input r1c2, input r2c0, input r2c1, input r2c2,
                 output ready);
endinterface

@@ hw/rtl/eulrot_rom.sv @@
// Quarter-wave sine ROM with registered read and read enable.
// Depends on eulrot_pkg (table contents and widths).
module eulrot_rom (
   input  logic                            clock,
   input  logic                            en,
   input  logic [eulrot_pkg::ADDR_W-1:0]   addr,
   output logic [eulrot_pkg::MAG_W-1:0]    data
);

   localparam eulrot_pkg::tab_type SINE_ROM = eulrot_pkg::build_sine_table();

   logic [eulrot_pkg::MAG_W-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= SINE_ROM[addr];
      end
   end

   assign data = data_ff;

endmodule

@@ hw/rtl/eulrot_phase.sv @@
// Angle to table phase: reduce modulo one turn, then scale to 4*SINE_TABLE_DEPTH steps.
// Three stages; depends on eulrot_pkg.
module eulrot_phase (
   input  logic                                   clock,
   input  logic [eulrot_pkg::PHASE_STAGES-1:0]    en,
   input  logic signed [eulrot_pkg::ANGLE_W-1:0]  angle,
   output logic [eulrot_pkg::PHASE_W-1:0]         phase
);

   logic [eulrot_pkg::MOD_W-1:0]   mod_in, mod_ff;
   logic [eulrot_pkg::N2_W-1:0]    n2_in, n2_ff;
   logic [eulrot_pkg::PRODQ_W-1:0] prod_in, prod_ff;
   logic [eulrot_pkg::PHASE_W-1:0] phase_in, phase_ff;

   // stage 1: angle mod one turn
   always_comb begin
      logic [eulrot_pkg::RED_W-1:0] t;
      t = eulrot_pkg::RED_W'(angle) + eulrot_pkg::RED_W'(eulrot_pkg::TWO_TURNS);
      if (t >= eulrot_pkg::RED_W'(eulrot_pkg::TWO_TURNS)) begin
         t = t - eulrot_pkg::RED_W'(eulrot_pkg::TWO_TURNS);
      end
      if (t >= eulrot_pkg::RED_W'(eulrot_pkg::FULL_TURN)) begin
         t = t - eulrot_pkg::RED_W'(eulrot_pkg::FULL_TURN);
      end
      mod_in = t[eulrot_pkg::MOD_W-1:0];
   end

   // stage 2: scaled numerator, reciprocal multiply by the odd factor of a turn
   always_comb begin
      logic [eulrot_pkg::NUM_W-1:0] num;
      num = (eulrot_pkg::NUM_W'(mod_ff) << (eulrot_pkg::TAB_LOG + 2))
            + eulrot_pkg::NUM_W'(eulrot_pkg::HALF_TURN);
      n2_in   = num[eulrot_pkg::NUM_W-1:eulrot_pkg::TURN_SHIFT];
      prod_in = eulrot_pkg::PRODQ_W'(n2_in) * eulrot_pkg::PRODQ_W'(eulrot_pkg::RECIP);
   end

   // stage 3: correct estimate, wrap a full turn to zero
   always_comb begin
      logic [eulrot_pkg::QE_W-1:0] q;
      q = prod_ff[eulrot_pkg::PRODQ_W-1:eulrot_pkg::RECIP_SHIFT];
      if (eulrot_pkg::CORR_W'(q) * eulrot_pkg::CORR_W'(eulrot_pkg::TURN_ODD)
          > eulrot_pkg::CORR_W'(n2_ff)) begin
         q = q - eulrot_pkg::QE_W'(1);
      end
      if (q >= eulrot_pkg::QE_W'(4 * eulrot_pkg::SINE_TABLE_DEPTH)) begin
         phase_in = '0;
      end else begin
         phase_in = q[eulrot_pkg::PHASE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         mod_ff <= mod_in;
      end
      if (en[1]) begin
         n2_ff   <= n2_in;
         prod_ff <= prod_in;
      end
      if (en[2]) begin
         phase_ff <= phase_in;
      end
   end

   assign phase = phase_ff;

endmodule

@@ hw/rtl/eulrot_sincos.sv @@
// Sine and cosine of one phase through two quarter-wave ROMs.
// Three stages; depends on eulrot_pkg and eulrot_rom.
module eulrot_sincos (
   input  logic                                   clock,
   input  logic [eulrot_pkg::SINCOS_STAGES-1:0]   en,
   input  logic [eulrot_pkg::PHASE_W-1:0]         phase,
   output logic signed [eulrot_pkg::VAL_W-1:0]    sin_val,
   output logic signed [eulrot_pkg::VAL_W-1:0]    cos_val
);

   logic [eulrot_pkg::ADDR_W-1:0]   addr_s_in, addr_s_ff, addr_c_in, addr_c_ff;
   logic                            neg_s_in, neg_s_ff, neg_c_in, neg_c_ff;
   logic                            neg_s2_ff, neg_c2_ff;
   logic [eulrot_pkg::MAG_W-1:0]    mag_s, mag_c;
   logic signed [eulrot_pkg::VAL_W-1:0] sin_in, sin_ff, cos_in, cos_ff;

   // stage 1: quadrant folding
   always_comb begin
      logic [eulrot_pkg::PHASE_W-1:0] pc;
      logic [eulrot_pkg::ADDR_W-1:0]  rs, rc;
      pc = phase + eulrot_pkg::PHASE_W'(eulrot_pkg::SINE_TABLE_DEPTH);
      rs = eulrot_pkg::ADDR_W'(phase[eulrot_pkg::TAB_LOG-1:0]);
      rc = eulrot_pkg::ADDR_W'(pc[eulrot_pkg::TAB_LOG-1:0]);
      addr_s_in = phase[eulrot_pkg::TAB_LOG]
                  ? eulrot_pkg::ADDR_W'(eulrot_pkg::SINE_TABLE_DEPTH) - rs : rs;
      addr_c_in = pc[eulrot_pkg::TAB_LOG]
                  ? eulrot_pkg::ADDR_W'(eulrot_pkg::SINE_TABLE_DEPTH) - rc : rc;
      neg_s_in = phase[eulrot_pkg::PHASE_W-1];
      neg_c_in = pc[eulrot_pkg::PHASE_W-1];
   end

   // stage 2: table read
   eulrot_rom u_rom_sin (
      .clock (clock),
      .en    (en[1]),
      .addr  (addr_s_ff),
      .data  (mag_s)
   );

   eulrot_rom u_rom_cos (
      .clock (clock),
      .en    (en[1]),
      .addr  (addr_c_ff),
      .data  (mag_c)
   );

   // stage 3: apply sign
   always_comb begin
      sin_in = signed'({1'b0, mag_s});
      cos_in = signed'({1'b0, mag_c});
      if (neg_s2_ff) begin
         sin_in = -sin_in;
      end
      if (neg_c2_ff) begin
         cos_in = -cos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         addr_s_ff <= addr_s_in;
         addr_c_ff <= addr_c_in;
         neg_s_ff  <= neg_s_in;
         neg_c_ff  <= neg_c_in;
      end
      if (en[1]) begin
         neg_s2_ff <= neg_s_ff;
         neg_c2_ff <= neg_c_ff;
      end
      if (en[2]) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule

@@ hw/rtl/eulrot_combine.sv @@
// Products and sums that form the nine matrix entries, with saturation.
// Five stages, the last is the output register; depends on eulrot_pkg.
module eulrot_combine (
   input  logic                                    clock,
   input  logic [eulrot_pkg::COMBINE_STAGES-1:0]   en,
   input  eulrot_pkg::trig_type                    trig,
   output eulrot_pkg::matrix_type                  matrix
);

   localparam int P_CXCZ = 0;
   localparam int P_CXSZ = 1;
   localparam int P_SXCZ = 2;
   localparam int P_SXSZ = 3;
   localparam int P_CYCZ = 4;
   localparam int P_CYSZ = 5;
   localparam int P_SXCY = 6;
   localparam int P_CXCY = 7;
   localparam int NPROD  = 8;
   localparam int NSY    = 4;

   logic signed [eulrot_pkg::VAL_W-1:0] opa [NPROD];
   logic signed [eulrot_pkg::VAL_W-1:0] opb [NPROD];

   logic [eulrot_pkg::PROD_W-1:0]       pm_ff [NPROD];
   logic                                ng_ff [NPROD];
   logic signed [eulrot_pkg::VAL_W-1:0] sy1_ff, sy2_ff, sy3_ff, sy4_ff;
   logic signed [eulrot_pkg::VAL_W-1:0] v2_ff [NPROD];
   logic signed [eulrot_pkg::VAL_W-1:0] v3_ff [NPROD];
   logic signed [eulrot_pkg::VAL_W-1:0] v4_ff [NPROD];
   logic [eulrot_pkg::PROD_W-1:0]       qm_ff [NSY];
   logic                                qn_ff [NSY];
   logic signed [eulrot_pkg::VAL_W-1:0] w4_ff [NSY];
   eulrot_pkg::matrix_type              mat_in, mat_ff;

   always_comb begin
      opa[P_CXCZ] = trig.cx;  opb[P_CXCZ] = trig.cz;
      opa[P_CXSZ] = trig.cx;  opb[P_CXSZ] = trig.sz;
      opa[P_SXCZ] = trig.sx;  opb[P_SXCZ] = trig.cz;
      opa[P_SXSZ] = trig.sx;  opb[P_SXSZ] = trig.sz;
      opa[P_CYCZ] = trig.cy;  opb[P_CYCZ] = trig.cz;
      opa[P_CYSZ] = trig.cy;  opb[P_CYSZ] = trig.sz;
      opa[P_SXCY] = trig.sx;  opb[P_SXCY] = trig.cy;
      opa[P_CXCY] = trig.cx;  opb[P_CXCY] = trig.cy;
   end

   // output stage: sums and clamp to [-1, +1]
   always_comb begin
      mat_in.r0c0 = eulrot_pkg::sat_pack((eulrot_pkg::VAL_W + 1)'(v4_ff[P_CYCZ]));
      mat_in.r0c1 = eulrot_pkg::sat_pack((eulrot_pkg::VAL_W + 1)'(w4_ff[P_SXCZ])
                                         - (eulrot_pkg::VAL_W + 1)'(v4_ff[P_CXSZ]));
      mat_in.r0c2 = eulrot_pkg::sat_pack((eulrot_pkg::VAL_W + 1)'(v4_ff[P_SXSZ])
                                         + (eulrot_pkg::VAL_W + 1)'(w4_ff[P_CXCZ]));
      mat_in.r1c0 = eulrot_pkg::sat_pack((eulrot_pkg::VAL_W + 1)'(v4_ff[P_CYSZ]));
      mat_in.r1c1 = eulrot_pkg::sat_pack((eulrot_pkg::VAL_W + 1)'(v4_ff[P_CXCZ])
                                         + (eulrot_pkg::VAL_W + 1)'(w4_ff[P_SXSZ]));
      mat_in.r1c2 = eulrot_pkg::sat_pack((eulrot_pkg::VAL_W + 1)'(w4_ff[P_CXSZ])
                                         - (eulrot_pkg::VAL_W + 1)'(v4_ff[P_SXCZ]));
      mat_in.r2c0 = eulrot_pkg::sat_pack(-(eulrot_pkg::VAL_W + 1)'(sy4_ff));
      mat_in.r2c1 = eulrot_pkg::sat_pack((eulrot_pkg::VAL_W + 1)'(v4_ff[P_SXCY]));
      mat_in.r2c2 = eulrot_pkg::sat_pack((eulrot_pkg::VAL_W + 1)'(v4_ff[P_CXCY]));
   end

   always_ff @(posedge clock) begin
      // stage 1: magnitude products of sine and cosine pairs
      if (en[0]) begin
         for (int k = 0; k < NPROD; k++) begin
            pm_ff[k] <= eulrot_pkg::PROD_W'(eulrot_pkg::mag_of(opa[k]))
                        * eulrot_pkg::PROD_W'(eulrot_pkg::mag_of(opb[k]));
            ng_ff[k] <= opa[k][eulrot_pkg::VAL_W-1] ^ opb[k][eulrot_pkg::VAL_W-1];
         end
         sy1_ff <= trig.sy;
      end
      // stage 2: round and sign
      if (en[1]) begin
         for (int k = 0; k < NPROD; k++) begin
            v2_ff[k] <= eulrot_pkg::round_prod(pm_ff[k], ng_ff[k]);
         end
         sy2_ff <= sy1_ff;
      end
      // stage 3: second products with sin y
      if (en[2]) begin
         for (int k = 0; k < NSY; k++) begin
            qm_ff[k] <= eulrot_pkg::PROD_W'(eulrot_pkg::mag_of(v2_ff[k]))
                        * eulrot_pkg::PROD_W'(eulrot_pkg::mag_of(sy2_ff));
            qn_ff[k] <= v2_ff[k][eulrot_pkg::VAL_W-1] ^ sy2_ff[eulrot_pkg::VAL_W-1];
         end
         for (int k = 0; k < NPROD; k++) begin
            v3_ff[k] <= v2_ff[k];
         end
         sy3_ff <= sy2_ff;
      end
      // stage 4: round and sign
      if (en[3]) begin
         for (int k = 0; k < NSY; k++) begin
            w4_ff[k] <= eulrot_pkg::round_prod(qm_ff[k], qn_ff[k]);
         end
         for (int k = 0; k < NPROD; k++) begin
            v4_ff[k] <= v3_ff[k];
         end
         sy4_ff <= sy3_ff;
      end
      if (en[4]) begin
         mat_ff <= mat_in;
      end
   end

   assign matrix = mat_ff;

endmodule

@@ hw/rtl/euler_xyz_rotation_matrix.sv @@
// Euler XYZ rotation matrix (R = Rz * Ry * Rx) from three angles in 1/64 degree, entries in
// signed Q2.14 clamped to [-1, +1]. The block is an 11-stage pipeline: 3 stages reduce each
// angle modulo 360 degrees and scale it to a table phase, 3 stages look up sine and cosine in
// six 1025-entry quarter-wave ROMs, and 5 stages form the products and sums, the last being
// the output register. It takes one word per cycle while the result side is ready; each
// result passes through every stage and waits in the output register until the result side
// takes it. Each stage holds its word while the stage after it is full and stalled, so empty
// stages still take new words during a stall. Depends on eulrot_pkg, eulrot_req_if,
// eulrot_rsp_if, eulrot_phase, eulrot_sincos and eulrot_combine.
module euler_xyz_rotation_matrix (
   input  logic                 clock,
   input  logic                 reset,
   eulrot_req_if.sink           req_ch,
   eulrot_rsp_if.source         rsp_ch
);

   localparam int SC_LO = eulrot_pkg::PHASE_STAGES;
   localparam int CB_LO = eulrot_pkg::PHASE_STAGES + eulrot_pkg::SINCOS_STAGES;
   localparam int LAST  = eulrot_pkg::NUM_STAGES - 1;

   logic [eulrot_pkg::NUM_STAGES-1:0] vld_in, vld_ff, en;

   logic [eulrot_pkg::PHASE_W-1:0]      px, py, pz;
   eulrot_pkg::trig_type                trig;
   eulrot_pkg::matrix_type              matrix;

   always_comb begin
      en[LAST] = !vld_ff[LAST] || rsp_ch.ready;
      for (int i = LAST - 1; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      vld_in[0] = en[0] ? req_ch.valid : vld_ff[0];
      for (int i = 1; i <= LAST; i++) begin
         vld_in[i] = en[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   eulrot_phase u_phase_x (
      .clock (clock),
      .en    (en[SC_LO-1:0]),
      .angle (req_ch.angle_x),
      .phase (px)
   );

   eulrot_phase u_phase_y (
      .clock (clock),
      .en    (en[SC_LO-1:0]),
      .angle (req_ch.angle_y),
      .phase (py)
   );

   eulrot_phase u_phase_z (
      .clock (clock),
      .en    (en[SC_LO-1:0]),
      .angle (req_ch.angle_z),
      .phase (pz)
   );

   eulrot_sincos u_sincos_x (
      .clock   (clock),
      .en      (en[CB_LO-1:SC_LO]),
      .phase   (px),
      .sin_val (trig.sx),
      .cos_val (trig.cx)
   );

   eulrot_sincos u_sincos_y (
      .clock   (clock),
      .en      (en[CB_LO-1:SC_LO]),
      .phase   (py),
      .sin_val (trig.sy),
      .cos_val (trig.cy)
   );

   eulrot_sincos u_sincos_z (
      .clock   (clock),
      .en      (en[CB_LO-1:SC_LO]),
      .phase   (pz),
      .sin_val (trig.sz),
      .cos_val (trig.cz)
   );

   eulrot_combine u_combine (
      .clock  (clock),
      .en     (en[LAST:CB_LO]),
      .trig   (trig),
      .matrix (matrix)
   );

   assign req_ch.ready = en[0];
   assign rsp_ch.valid = vld_ff[LAST];
   assign rsp_ch.r0c0  = matrix.r0c0;
   assign rsp_ch.r0c1  = matrix.r0c1;
   assign rsp_ch.r0c2  = matrix.r0c2;
   assign rsp_ch.r1c0  = matrix.r1c0;
   assign rsp_ch.r1c1  = matrix.r1c1;
   assign rsp_ch.r1c2  = matrix.r1c2;
   assign rsp_ch.r2c0  = matrix.r2c0;
   assign rsp_ch.r2c1  = matrix.r2c1;
   assign rsp_ch.r2c2  = matrix.r2c2;

endmodule

@@ tb/euler_xyz_rotation_matrix_chk.sv @@
// Checker for the Euler XYZ rotation matrix block: watches both channels, computes the
// expected matrix for every accepted angle word and compares the result words entry by entry.
// Depends on eulrot_pkg, eulrot_req_if and eulrot_rsp_if.
module euler_xyz_rotation_matrix_chk (
   input  logic   clock,
   input  logic   reset,
   eulrot_req_if  req_ch,
   eulrot_rsp_if  rsp_ch,
   output int     fail_count,
   output int     pending
);
   import eulrot_pkg::*;

   localparam int DEPTH = SINE_TABLE_DEPTH;
   localparam int FRAC  = OUT_FRAC_BITS;
   localparam longint UNIT = longint'(1) << FRAC;

   // index 0 is r0c0, index 8 is r2c2
   typedef logic [8:0][OUT_W-1:0] matrix_words_t;

   logic [MAG_W-1:0] quarter_sine [0:DEPTH];
   matrix_words_t    matrix_q [$];
   string entry_name [9] = '{"r0c0", "r0c1", "r0c2", "r1c0", "r1c1", "r1c2",
                             "r2c0", "r2c1", "r2c2"};

   // quarter-wave sine via Q30 Taylor series, rounded half up to Q(FRAC)
   initial begin
      longint unsigned ang_q30;
      longint unsigned ang_sq;
      longint unsigned term;
      longint          acc;
      fail_count = 0;
      pending    = 0;
      for (int i = 0; i <= DEPTH; i++) begin
         ang_q30 = (longint'(i) * HALF_PI_Q30 + DEPTH / 2) / DEPTH;
         ang_sq  = (ang_q30 * ang_q30 + (longint'(1) << 29)) >> 30;
         term    = ang_q30;
         acc     = longint'(ang_q30);
         for (int k = 1; k <= 12; k++) begin
            term = ((term * ang_sq) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         if (acc > (longint'(1) << 30)) begin
            acc = longint'(1) << 30;
         end
         quarter_sine[i] = MAG_W'((acc + (longint'(1) << (29 - FRAC))) >> (30 - FRAC));
      end
      quarter_sine[0]     = '0;
      quarter_sine[DEPTH] = MAG_W'(UNIT);
   end

   function automatic int angle_to_phase(logic signed [ANGLE_W-1:0] a);
      int     m;
      longint p;
      m = int'(a) % FULL_TURN;
      if (m < 0) begin
         m = m + FULL_TURN;
      end
      p = (longint'(m) * 4 * DEPTH + FULL_TURN / 2) / FULL_TURN;
      if (p >= 4 * DEPTH) begin
         p = 0;
      end
      return int'(p);
   endfunction

   function automatic longint sine_at(int p);
      int r;
      r = p % DEPTH;
      case ((p / DEPTH) % 4)
         0: begin
            return longint'(quarter_sine[r]);
         end
         1: begin
            return longint'(quarter_sine[DEPTH - r]);
         end
         2: begin
            return -longint'(quarter_sine[r]);
         end
         default: begin
            return -longint'(quarter_sine[DEPTH - r]);
         end
      endcase
   endfunction

   function automatic longint cosine_at(int p);
      return sine_at((p + DEPTH) % (4 * DEPTH));
   endfunction

   // magnitude rounded half away from zero, sign applied after
   function automatic longint q_mul(longint a, longint b);
      logic   neg;
      longint m;
      neg = (a < 0) != (b < 0);
      m   = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + (longint'(1) << (FRAC - 1))) >>> FRAC;
      return neg ? -m : m;
   endfunction

   function automatic logic [OUT_W-1:0] clamp_entry(longint v);
      if (v > UNIT) begin
         v = UNIT;
      end else if (v < -UNIT) begin
         v = -UNIT;
      end
      return OUT_W'(v);
   endfunction

   function automatic matrix_words_t rotation_of(logic signed [ANGLE_W-1:0] ax,
                                                 logic signed [ANGLE_W-1:0] ay,
                                                 logic signed [ANGLE_W-1:0] az);
      matrix_words_t w;
      int     px, py, pz;
      longint sx, cx, sy, cy, sz, cz, cxcz, cxsz, sxcz, sxsz;
      px   = angle_to_phase(ax);
      py   = angle_to_phase(ay);
      pz   = angle_to_phase(az);
      sx   = sine_at(px);
      cx   = cosine_at(px);
      sy   = sine_at(py);
      cy   = cosine_at(py);
      sz   = sine_at(pz);
      cz   = cosine_at(pz);
      cxcz = q_mul(cx, cz);
      cxsz = q_mul(cx, sz);
      sxcz = q_mul(sx, cz);
      sxsz = q_mul(sx, sz);
      w[0] = clamp_entry(q_mul(cy, cz));
      w[1] = clamp_entry(q_mul(sxcz, sy) - cxsz);
      w[2] = clamp_entry(sxsz + q_mul(cxcz, sy));
      w[3] = clamp_entry(q_mul(cy, sz));
      w[4] = clamp_entry(cxcz + q_mul(sxsz, sy));
      w[5] = clamp_entry(q_mul(cxsz, sy) - sxcz);
      w[6] = clamp_entry(-sy);
      w[7] = clamp_entry(q_mul(sx, cy));
      w[8] = clamp_entry(q_mul(cx, cy));
      return w;
   endfunction

   always @(posedge clock) begin
      matrix_words_t got;
      matrix_words_t want;
      if (reset) begin
         matrix_q.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            matrix_q.push_back(rotation_of(req_ch.angle_x, req_ch.angle_y, req_ch.angle_z));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.r2c2, rsp_ch.r2c1, rsp_ch.r2c0, rsp_ch.r1c2, rsp_ch.r1c1,
                   rsp_ch.r1c0, rsp_ch.r0c2, rsp_ch.r0c1, rsp_ch.r0c0};
            if (matrix_q.size() == 0) begin
               $error("matrix word with no angle word outstanding");
               fail_count = fail_count + 1;
            end else begin
               want = matrix_q.pop_front();
               for (int i = 0; i < 9; i++) begin
                  if (got[i] !== want[i]) begin
                     $error("%s: expected %0d, got %0d", entry_name[i],
                            $signed(want[i]), $signed(got[i]));
                     fail_count = fail_count + 1;
                  end
               end
            end
         end
      end
      pending = matrix_q.size();
   end

endmodule

@@ tb/euler_xyz_rotation_matrix_tb.sv @@
// Top of the Euler XYZ rotation matrix testbench: clock, reset, angle stimulus, result-side
// back-pressure, watchdog and verdict. Depends on eulrot_pkg, both channel interfaces,
// euler_xyz_rotation_matrix and euler_xyz_rotation_matrix_chk.
module euler_xyz_rotation_matrix_tb;
   import eulrot_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 3 * NUM_STAGES;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   src_idle_pct;
   int   sink_stall_pct;
   int   hold_cycles;
   int   quiet_cycles;

   eulrot_req_if req_ch ();
   eulrot_rsp_if rsp_ch ();

   euler_xyz_rotation_matrix dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   euler_xyz_rotation_matrix_chk chk (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic signed [ANGLE_W-1:0] pick_angle();
      int kind;
      int k;
      int r;
      kind = $urandom_range(0, 9);
      k    = int'($urandom_range(0, 10)) - 5;
      r    = int'($urandom_range(0, 8)) - 4;
      if (kind < 5) begin
         return ANGLE_W'($urandom);
      end else if (kind < 8) begin
         // around quarter turns
         return ANGLE_W'(k * (FULL_TURN / 4) + r);
      end else if (kind == 8) begin
         return $urandom_range(0, 1) ? ANGLE_W'(32767 - r - 4) : ANGLE_W'(-32768 + r + 4);
      end else begin
         return ANGLE_W'(int'($urandom_range(0, 128)) - 64);
      end
   endfunction

   // entered and left at a falling edge
   task automatic send(input logic signed [ANGLE_W-1:0] ax, input logic signed [ANGLE_W-1:0] ay,
                       input logic signed [ANGLE_W-1:0] az);
      while (int'($urandom_range(0, 99)) < src_idle_pct) begin
         req_ch.valid   <= 1'b0;
         req_ch.angle_x <= ANGLE_W'($urandom);
         req_ch.angle_y <= ANGLE_W'($urandom);
         req_ch.angle_z <= ANGLE_W'($urandom);
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.angle_x <= ax;
      req_ch.angle_y <= ay;
      req_ch.angle_z <= az;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) begin
         send(pick_angle(), pick_angle(), pick_angle());
      end
   endtask

   // result side
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
         end else begin
            rsp_ch.ready <= int'($urandom_range(0, 99)) >= sink_stall_pct;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** euler_xyz_rotation_matrix: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      quiet_cycles   = 0;
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      hold_cycles    = 0;
      req_ch.valid   = 1'b0;
      req_ch.angle_x = '0;
      req_ch.angle_y = '0;
      req_ch.angle_z = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // extremes, quarter turns, wrap of the phase near a full turn
      send(0, 0, 0);
      send(32767, 32767, 32767);
      send(-32768, -32768, -32768);
      send(5760, 0, 0);
      send(0, 5760, 0);
      send(0, 0, 5760);
      send(11520, 11520, 11520);
      send(17280, -5760, 23040);
      send(-23040, 23039, -1);
      send(-2, -3, 23038);
      send(23037, -23037, 23036);
      send(2880, 2880, 2880);
      send(-2880, 2880, -2880);
      send(1, -1, 64);
      send(5760, 5760, 5760);
      send(-5760, -5760, 5760);
      send(32767, -32768, 0);
      send(21845, -21846, 10922);
      send(1920, 3840, 7680);
      send(960, -960, 12345);
      send(-11520, 17280, 2880);

      // long receiver hold-off while words keep coming
      hold_cycles = 200;
      send_random(250);

      src_idle_pct = 48;
      send_random(250);

      src_idle_pct   = 0;
      sink_stall_pct = 48;
      send_random(250);

      src_idle_pct   = 38;
      sink_stall_pct = 38;
      send_random(250);

      src_idle_pct   = 0;
      sink_stall_pct = 0;
      send_random(50);

      req_ch.valid <= 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0) begin
         $display("** euler_xyz_rotation_matrix: PASSED **");
      end else begin
         $display("** euler_xyz_rotation_matrix: FAILED **");
      end
      $finish;
   end

endmodule
